// File: rtl/e2c_pkg.sv
// Shared constants and calendar helper functions for the epoch-to-calendar block.
// No dependencies; imported by e2c_month_split and epoch_seconds_to_calendar_top.
package e2c_pkg;

   localparam int unsigned DAY_W   = 16;  // whole days since epoch, < 49711
   localparam int unsigned YOFF_W  = 8;   // years since 1970, 0..136
   localparam int unsigned DOY_W   = 9;   // day of year, 0..365
   localparam int unsigned EPOCH_YEAR = 1970;

   // floor-type reciprocals: q = (x * MUL) >> SHIFT
   localparam logic [25:0] DAY_MUL   = 26'd50903316;  // (t>>7)/675, off by at most -1
   localparam int unsigned DAY_SHIFT = 35;
   localparam logic [16:0] SEC_PER_DAY = 17'd86400;
   localparam logic [17:0] HOUR_MUL  = 18'd149131;    // exact for x < 86400
   localparam int unsigned HOUR_SHIFT = 29;
   localparam logic [16:0] WDAY_MUL  = 17'd74899;     // exact /7 for x < 104859
   localparam int unsigned WDAY_SHIFT = 19;
   localparam logic [19:0] YEAR_MUL  = 20'd734939;    // 4d/1461, exact over range
   localparam int unsigned YEAR_SHIFT = 30;
   localparam logic [11:0] MIN_MUL   = 12'd2185;      // exact /60 for x < 3600
   localparam int unsigned MIN_SHIFT = 17;
   localparam logic [7:0]  CENTURY_YOFF = 8'd130;     // 2100, not a leap year

   // days from 1970-01-01 to Jan 1 of year 1970+yo
   function automatic logic [DAY_W-1:0] days_before_year(input logic [YOFF_W-1:0] yo);
      logic [YOFF_W:0] y1;
      logic [16:0]     acc;
      y1  = {1'b0, yo} + 9'd1;
      acc = 17'(yo) * 17'd365 + 17'(y1[YOFF_W:2]);
      if (yo > CENTURY_YOFF) begin
         acc = acc - 17'd1;
      end
      return acc[DAY_W-1:0];
   endfunction

   // days of the year that come before month index mo (0 = January)
   function automatic logic [DOY_W-1:0] days_before_month(input logic [3:0] mo,
                                                          input logic       leap);
      logic [DOY_W-1:0] base;
      case (mo)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (mo >= 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

// File: rtl/e2c_month_split.sv
// Two-stage split of a day of year into month and day of month.
// Depends on e2c_pkg (days_before_month).
module e2c_month_split
   import e2c_pkg::*;
(
   input  logic             clock,
   input  logic             ce,
   input  logic [DOY_W-1:0] doy,
   input  logic             leap,
   output logic [3:0]       month,
   output logic [4:0]       day
);

   logic [3:0]       mo_ff, mo_in;
   logic [DOY_W-1:0] doy_ff;
   logic             leap_ff;
   logic [3:0]       month_ff, month_in;
   logic [4:0]       day_ff, day_in;
   logic [DOY_W-1:0] rest;

   // month index = number of month starts after January at or below doy
   always_comb begin
      mo_in = 4'd0;
      for (int m = 1; m < 12; m++) begin
         if (doy >= days_before_month(4'(m), leap)) begin
            mo_in = mo_in + 4'd1;
         end
      end
   end

   always_comb begin
      rest     = doy_ff - days_before_month(mo_ff, leap_ff);
      day_in   = rest[4:0] + 5'd1;
      month_in = mo_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         mo_ff    <= mo_in;
         doy_ff   <= doy;
         leap_ff  <= leap;
         month_ff <= month_in;
         day_ff   <= day_in;
      end
   end

   assign month = month_ff;
   assign day   = day_ff;

endmodule

// File: rtl/epoch_seconds_to_calendar_top.sv
// Top level: epoch seconds to Gregorian date and time of day, stream in and out.
// Depends on e2c_pkg and e2c_month_split.
// The req transaction passes through nine register stages A..I before rsp_tvalid
// rises; one transaction per cycle while no result waits on rsp_tready.
// Throughput is set by a single enable that moves all stages together; it drops only
// while the output register holds a result that rsp_tready has not taken.
// Reset (synchronous, active high) clears the stage valid bits; data regs are not reset.
module epoch_seconds_to_calendar_top
   import e2c_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] epoch_seconds
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // second[5:0] minute[11:6] hour[16:12] weekday[19:17]
                                    // year[31:20] month[35:32] day[40:36], zeros above
);

   // Pipeline:
   //  A  (t>>7) * reciprocal of 675      -> approximate day count
   //  B  q0 and remainder t - q0*86400 (q0 may be one low)
   //  C  one-step correction -> days d, seconds of day rem
   //  D  three reciprocal products: hour, weekday, year estimate
   //  E  hour, rem2 = seconds within hour, weekday, year estimate Ye
   //  F  minute product, start days of years Ye-1, Ye, Ye+1
   //  G  minute, second, pick year, day of year, leap flag
   //  H,I month split (submodule)
   localparam int unsigned NSTAGE = 9;

   logic              ce;
   logic [NSTAGE-1:0] v_ff;

   assign ce         = !v_ff[NSTAGE-1] || rsp_tready;
   assign req_tready = ce;
   assign rsp_tvalid = v_ff[NSTAGE-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (ce) begin
         v_ff <= {v_ff[NSTAGE-2:0], req_tvalid};
      end
   end

   // ---- stage A
   logic [31:0] a_t_ff;
   logic [50:0] a_p_ff, a_p_in;
   assign a_p_in = 51'(req_tdata[31:7]) * 51'(DAY_MUL);

   // ---- stage B
   logic [DAY_W-1:0] b_q_ff, b_q_in;
   logic [17:0]      b_r_ff, b_r_in;
   logic [32:0]      b_qs;
   always_comb begin
      b_q_in = a_p_ff[DAY_SHIFT +: DAY_W];
      b_qs   = 33'(b_q_in) * 33'(SEC_PER_DAY);
      b_r_in = 18'(33'(a_t_ff) - b_qs);
   end

   // ---- stage C
   logic [DAY_W-1:0] c_d_ff, c_d_in;
   logic [16:0]      c_rem_ff, c_rem_in;
   always_comb begin
      if (b_r_ff >= 18'(SEC_PER_DAY)) begin
         c_d_in   = b_q_ff + 16'd1;
         c_rem_in = 17'(b_r_ff - 18'(SEC_PER_DAY));
      end else begin
         c_d_in   = b_q_ff;
         c_rem_in = b_r_ff[16:0];
      end
   end

   // ---- stage D
   logic [DAY_W-1:0] d_d_ff;
   logic [16:0]      d_rem_ff;
   logic [16:0]      d_w_ff, d_w_in;
   logic [34:0]      d_ph_ff, d_ph_in;
   logic [33:0]      d_pw_ff, d_pw_in;
   logic [37:0]      d_py_ff, d_py_in;
   always_comb begin
      d_w_in  = 17'(c_d_ff) + 17'd4;          // epoch day was a Thursday
      d_ph_in = 35'(c_rem_ff) * 35'(HOUR_MUL);
      d_pw_in = 34'(d_w_in) * 34'(WDAY_MUL);
      d_py_in = 38'({c_d_ff, 2'b00}) * 38'(YEAR_MUL);
   end

   // ---- stage E
   logic [DAY_W-1:0]  e_d_ff;
   logic [4:0]        e_hr_ff, e_hr_in;
   logic [11:0]       e_rem2_ff, e_rem2_in;
   logic [2:0]        e_wd_ff, e_wd_in;
   logic [YOFF_W-1:0] e_ye_ff, e_ye_in;
   logic [14:0]       e_wq;
   always_comb begin
      e_hr_in   = d_ph_ff[HOUR_SHIFT +: 5];
      e_rem2_in = 12'(d_rem_ff - 17'(e_hr_in) * 17'd3600);
      e_wq      = d_pw_ff[WDAY_SHIFT +: 15];
      e_wd_in   = 3'(d_w_ff - 17'(e_wq) * 17'd7);
      e_ye_in   = d_py_ff[YEAR_SHIFT +: YOFF_W];
   end

   // ---- stage F
   logic [DAY_W-1:0]  f_d_ff;
   logic [4:0]        f_hr_ff;
   logic [11:0]       f_rem2_ff;
   logic [2:0]        f_wd_ff;
   logic [YOFF_W-1:0] f_ye_ff;
   logic [23:0]       f_pm_ff, f_pm_in;
   logic [DAY_W-1:0]  f_db0_ff, f_db0_in, f_db1_ff, f_db1_in, f_dbm_ff, f_dbm_in;
   always_comb begin
      f_pm_in  = 24'(e_rem2_ff) * 24'(MIN_MUL);
      f_db0_in = days_before_year(e_ye_ff);
      f_db1_in = days_before_year(e_ye_ff + 8'd1);
      f_dbm_in = days_before_year(e_ye_ff - 8'd1);
   end

   // ---- stage G
   logic [4:0]        g_hr_ff;
   logic [2:0]        g_wd_ff;
   logic [5:0]        g_mn_ff, g_mn_in, g_sec_ff, g_sec_in;
   logic [11:0]       g_year_ff, g_year_in;
   logic [DOY_W-1:0]  g_doy_ff, g_doy_in;
   logic              g_leap_ff, g_leap_in;
   logic [YOFF_W-1:0] g_y;
   logic [DAY_W-1:0]  g_base;
   always_comb begin
      g_mn_in  = f_pm_ff[MIN_SHIFT +: 6];
      g_sec_in = 6'(f_rem2_ff - 12'(g_mn_in) * 12'd60);
      // estimate is within one year of the answer
      if (f_d_ff >= f_db1_ff) begin
         g_y    = f_ye_ff + 8'd1;
         g_base = f_db1_ff;
      end else if ((f_d_ff >= f_db0_ff) || (f_ye_ff == 8'd0)) begin
         g_y    = f_ye_ff;
         g_base = f_db0_ff;
      end else begin
         g_y    = f_ye_ff - 8'd1;
         g_base = f_dbm_ff;
      end
      g_doy_in  = 9'(f_d_ff - g_base);
      g_year_in = 12'(EPOCH_YEAR) + 12'(g_y);
      g_leap_in = (g_y[1:0] == 2'd2) && (g_y != CENTURY_YOFF);
   end

   // ---- stages H, I: time fields ride alongside the month split
   logic [5:0]  h_sec_ff, h_mn_ff, i_sec_ff, i_mn_ff;
   logic [4:0]  h_hr_ff, i_hr_ff;
   logic [2:0]  h_wd_ff, i_wd_ff;
   logic [11:0] h_year_ff, i_year_ff;
   logic [3:0]  i_month;
   logic [4:0]  i_day;

   e2c_month_split u_month (
      .clock (clock),
      .ce    (ce),
      .doy   (g_doy_ff),
      .leap  (g_leap_ff),
      .month (i_month),
      .day   (i_day)
   );

   always_ff @(posedge clock) begin
      if (ce) begin
         a_t_ff    <= req_tdata;
         a_p_ff    <= a_p_in;
         b_q_ff    <= b_q_in;
         b_r_ff    <= b_r_in;
         c_d_ff    <= c_d_in;
         c_rem_ff  <= c_rem_in;
         d_d_ff    <= c_d_ff;
         d_rem_ff  <= c_rem_ff;
         d_w_ff    <= d_w_in;
         d_ph_ff   <= d_ph_in;
         d_pw_ff   <= d_pw_in;
         d_py_ff   <= d_py_in;
         e_d_ff    <= d_d_ff;
         e_hr_ff   <= e_hr_in;
         e_rem2_ff <= e_rem2_in;
         e_wd_ff   <= e_wd_in;
         e_ye_ff   <= e_ye_in;
         f_d_ff    <= e_d_ff;
         f_hr_ff   <= e_hr_ff;
         f_rem2_ff <= e_rem2_ff;
         f_wd_ff   <= e_wd_ff;
         f_ye_ff   <= e_ye_ff;
         f_pm_ff   <= f_pm_in;
         f_db0_ff  <= f_db0_in;
         f_db1_ff  <= f_db1_in;
         f_dbm_ff  <= f_dbm_in;
         g_hr_ff   <= f_hr_ff;
         g_wd_ff   <= f_wd_ff;
         g_mn_ff   <= g_mn_in;
         g_sec_ff  <= g_sec_in;
         g_year_ff <= g_year_in;
         g_doy_ff  <= g_doy_in;
         g_leap_ff <= g_leap_in;
         h_sec_ff  <= g_sec_ff;
         h_mn_ff   <= g_mn_ff;
         h_hr_ff   <= g_hr_ff;
         h_wd_ff   <= g_wd_ff;
         h_year_ff <= g_year_ff;
         i_sec_ff  <= h_sec_ff;
         i_mn_ff   <= h_mn_ff;
         i_hr_ff   <= h_hr_ff;
         i_wd_ff   <= h_wd_ff;
         i_year_ff <= h_year_ff;
      end
   end

   assign rsp_tdata = {7'b0, i_day, i_month, i_year_ff, i_wd_ff, i_hr_ff, i_mn_ff, i_sec_ff};

   // ---- checks on the delivered transaction and on the stage C correction
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (i_sec_ff < 6'd60) && (i_mn_ff < 6'd60) && (i_hr_ff < 5'd24))
      else $error("time of day out of range");

   a_wday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (i_wd_ff < 3'd7))
      else $error("weekday out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (i_month >= 4'd1) && (i_month <= 4'd12) && (i_day >= 5'd1)
                     && (i_year_ff >= 12'd1970) && (i_year_ff <= 12'd2106))
      else $error("date out of range");

   a_day_corr: assert property (@(posedge clock) disable iff (reset)
      v_ff[2] |-> (c_rem_ff < SEC_PER_DAY))
      else $error("seconds of day not reduced");

endmodule
